[hw/rtl/ptl_pkg.sv]
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types, field widths and operation/status codes for the peer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptl_pkg;

  localparam int MAX_PEERS_DEFAULT = 16;

  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int WORD_W   = 64;
  localparam int PORT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  localparam int KEY_BYTES = 32;
  localparam int KEY_BITS  = KEY_BYTES * 8;

  // operations
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEARNED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   peer_id;
    logic [WORD_W-1:0] pubkey_word0;
    logic [WORD_W-1:0] pubkey_word1;
    logic [WORD_W-1:0] pubkey_word2;
    logic [WORD_W-1:0] pubkey_word3;
    logic [PORT_W-1:0] source_port;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [ID_W-1:0]     matched_peer_id;
    logic [COUNT_W-1:0]  active_count;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/ptl_req_if.sv]
// ----------------------------------------------------------------------------
// ptl_req_if
// Request channel: valid/ready handshake carrying one table operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ptl_req_if;
  logic                       valid;
  logic                       ready;
  logic [ptl_pkg::OP_W-1:0]   operation;
  logic [ptl_pkg::ID_W-1:0]   peer_id;
  logic [ptl_pkg::WORD_W-1:0] pubkey_word0;
  logic [ptl_pkg::WORD_W-1:0] pubkey_word1;
  logic [ptl_pkg::WORD_W-1:0] pubkey_word2;
  logic [ptl_pkg::WORD_W-1:0] pubkey_word3;
  logic [ptl_pkg::PORT_W-1:0] source_port;

  modport source (
    output valid, operation, peer_id, pubkey_word0, pubkey_word1,
           pubkey_word2, pubkey_word3, source_port,
    input  ready
  );

  modport sink (
    input  valid, operation, peer_id, pubkey_word0, pubkey_word1,
           pubkey_word2, pubkey_word3, source_port,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/ptl_rsp_if.sv]
// ----------------------------------------------------------------------------
// ptl_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ptl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ptl_pkg::STATUS_W-1:0] status;
  logic [ptl_pkg::SLOT_W-1:0]   slot_index;
  logic [ptl_pkg::ID_W-1:0]     matched_peer_id;
  logic [ptl_pkg::COUNT_W-1:0]  active_count;

  modport source (
    output valid, status, slot_index, matched_peer_id, active_count,
    input  ready
  );

  modport sink (
    input  valid, status, slot_index, matched_peer_id, active_count,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/peer_table_with_port_learning_core.sv]
// ----------------------------------------------------------------------------
// peer_table_with_port_learning_core
// Associative peer table: add, remove by key, source-port lookup with
// learning, find by id.
// ----------------------------------------------------------------------------
// The block takes one request beat per cycle, as rsp.ready allows, and gives
// one response beat per request, in order. A beat accepted on req is
// registered, then resolved against the table once the response register is
// empty or being drained, by a parallel compare of every entry (id, 256-bit
// key, learned port) and a lowest-index priority select; the table update and
// the response register load on the same edge, so the next request sees the
// updated table. The result passes the input register and then the response
// register before rsp valid; sustained rate is one beat per cycle, limited
// only by rsp.ready.
// While the response register holds an untaken beat, one more request is
// still taken into the input register. The active flags and the entry count
// clear at reset; entry payload is written when a slot is filled, so no
// clearing pass is needed. MAX_PEERS sets the number of entries; slot_index
// and active_count carry the low 4 and 5 bits of slot number and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peer_table_with_port_learning_core #(
  parameter int MAX_PEERS = ptl_pkg::MAX_PEERS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ptl_req_if.sink    req,
  ptl_rsp_if.source  rsp
);

  // input register
  logic          s1_valid;
  ptl_pkg::req_t s1_item;
  logic          s1_fire;

  // response register
  logic          out_valid;
  ptl_pkg::res_t out_res;
  ptl_pkg::res_t res;

  // stage 1 resolves when the response register is empty or being drained
  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.operation    <= req.operation;
      s1_item.peer_id      <= req.peer_id;
      s1_item.pubkey_word0 <= req.pubkey_word0;
      s1_item.pubkey_word1 <= req.pubkey_word1;
      s1_item.pubkey_word2 <= req.pubkey_word2;
      s1_item.pubkey_word3 <= req.pubkey_word3;
      s1_item.source_port  <= req.source_port;
    end
  end

  ptl_table #(
    .MAX_PEERS (MAX_PEERS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .item   (s1_item),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_res.status;
  assign rsp.slot_index      = out_res.slot_index;
  assign rsp.matched_peer_id = out_res.matched_peer_id;
  assign rsp.active_count    = out_res.active_count;

endmodule

`default_nettype wire

[hw/rtl/ptl_table.sv]
// ----------------------------------------------------------------------------
// ptl_table
// Entry storage with parallel id/key/port match, priority select and update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptl_table #(
  parameter int MAX_PEERS = ptl_pkg::MAX_PEERS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  ptl_pkg::req_t      item,
  output ptl_pkg::res_t      result
);

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int LW = $clog2(MAX_PEERS + 1);

  // state
  logic [MAX_PEERS-1:0]         active;
  logic [LW-1:0]                live;
  logic [ptl_pkg::ID_W-1:0]     pid  [MAX_PEERS];
  ptl_pkg::key_t                key  [MAX_PEERS];
  logic [ptl_pkg::PORT_W-1:0]   port [MAX_PEERS];

  // match lines
  ptl_pkg::key_t        req_key;
  logic [MAX_PEERS-1:0] id_hit, key_hit, port_hit, zero_hit;

  logic [IW-1:0]        id_idx, key_idx, port_idx, zero_idx, free_idx, slot;
  logic [MAX_PEERS-1:0] active_next;
  logic [LW-1:0]        live_next;
  logic                 wr_add, wr_learn, hit;
  logic [ptl_pkg::STATUS_W-1:0] status;

  // lowest set bit
  function automatic logic [IW-1:0] lowest(input logic [MAX_PEERS-1:0] vec);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = MAX_PEERS - 1; i >= 0; i--) begin
      if (vec[i]) idx = IW'(i);
    end
    return idx;
  endfunction

  assign req_key = {item.pubkey_word3, item.pubkey_word2,
                    item.pubkey_word1, item.pubkey_word0};

  always_comb begin
    for (int i = 0; i < MAX_PEERS; i++) begin
      id_hit[i]   = active[i] && (pid[i] == item.peer_id);
      key_hit[i]  = active[i] && (key[i] == req_key);
      port_hit[i] = active[i] && (port[i] == item.source_port);
      zero_hit[i] = active[i] && (port[i] == '0);
    end
  end

  assign id_idx   = lowest(id_hit);
  assign key_idx  = lowest(key_hit);
  assign port_idx = lowest(port_hit);
  assign zero_idx = lowest(zero_hit);
  assign free_idx = lowest(~active);

  always_comb begin
    status      = ptl_pkg::ST_NOT_FOUND;
    slot        = '0;
    wr_add      = 1'b0;
    wr_learn    = 1'b0;
    active_next = active;
    live_next   = live;
    case (item.operation)
      ptl_pkg::OP_ADD: begin
        if (|id_hit) begin
          status = ptl_pkg::ST_FOUND;
          slot   = id_idx;
        end else if (!(&active)) begin
          status            = ptl_pkg::ST_ADDED;
          slot              = free_idx;
          wr_add            = 1'b1;
          active_next[slot] = 1'b1;
          live_next         = live + LW'(1);
        end else begin
          status = ptl_pkg::ST_FULL;
        end
      end
      ptl_pkg::OP_REMOVE: begin
        if (|key_hit) begin
          status            = ptl_pkg::ST_REMOVED;
          slot              = key_idx;
          active_next[slot] = 1'b0;
          live_next         = live - LW'(1);
        end
      end
      ptl_pkg::OP_LOOKUP: begin
        if (|port_hit) begin
          status = ptl_pkg::ST_FOUND;
          slot   = port_idx;
        end else if (|zero_hit) begin
          status   = ptl_pkg::ST_LEARNED;
          slot     = zero_idx;
          wr_learn = 1'b1;
        end
      end
      ptl_pkg::OP_FIND: begin
        if (|id_hit) begin
          status = ptl_pkg::ST_FOUND;
          slot   = id_idx;
        end
      end
      default: begin
        status = ptl_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  assign hit = (status != ptl_pkg::ST_NOT_FOUND) && (status != ptl_pkg::ST_FULL);

  always_comb begin
    result.status          = status;
    result.active_count    = ptl_pkg::COUNT_W'(live_next);
    result.slot_index      = '0;
    result.matched_peer_id = '0;
    if (hit) begin
      result.slot_index      = ptl_pkg::SLOT_W'(slot);
      // a fresh entry takes the request id this cycle
      result.matched_peer_id = wr_add ? item.peer_id : pid[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      live   <= '0;
    end else if (fire) begin
      active <= active_next;
      live   <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_add) begin
      pid[slot]  <= item.peer_id;
      key[slot]  <= req_key;
      port[slot] <= '0;
    end else if (fire && wr_learn) begin
      port[slot] <= item.source_port;
    end
  end

`ifndef NO_ASSERTIONS
  a_live_matches_flags: assert property (@(posedge clk) disable iff (rst)
    live == LW'($countones(active)))
    else $error("live count out of step with active flags");

  a_add_sets_flag: assert property (@(posedge clk) disable iff (rst)
    fire && (status == ptl_pkg::ST_ADDED) |=> active[$past(slot)])
    else $error("added slot not active");

  a_remove_drops_one: assert property (@(posedge clk) disable iff (rst)
    fire && (status == ptl_pkg::ST_REMOVED) |=>
      ($countones(active) + 1 == $past($countones(active))))
    else $error("remove did not clear exactly one entry");

  a_no_dup_id_add: assert property (@(posedge clk) disable iff (rst)
    fire && wr_add |-> !(|id_hit))
    else $error("add of an id already present");
`endif

endmodule

`default_nettype wire

[tb/peer_table_with_port_learning_core_tb.sv]
// ----------------------------------------------------------------------------
// peer_table_with_port_learning_core_tb
// Self-checking bench for the peer table: a mirror of the table predicts each
// response beat from every accepted request beat, and the responses are
// compared field by field in order. Directed beats cover the empty table,
// filling to full, duplicate ids and keys, and port learning, including the
// zero port. Random traffic then swings the table between full and empty under
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_table_with_port_learning_core_tb;
  import ptl_pkg::*;

  localparam int NPEERS       = MAX_PEERS_DEFAULT;
  localparam int RANDOM_BEATS = 800;
  localparam int HOLD_CYCLES  = 120;      // one long receiver hold-off
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ID_POOL      = 24;
  localparam int KEY_POOL     = 8;
  localparam int PORT_POOL    = 8;

  // --------------------------------------------------------------------------
  // Table mirror: holds its own copy of the table, computes the response of
  // every request beat and keeps the responses still owed by the block.
  // --------------------------------------------------------------------------
  class peer_table_mirror;
    bit                occupied[NPEERS];
    logic [ID_W-1:0]   peer_ids[NPEERS];
    key_t              keys[NPEERS];
    logic [PORT_W-1:0] ports[NPEERS];
    int                live;
    res_t              pending_responses[$];
    int                mismatches;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      live       = 0;
      mismatches = 0;
    endfunction

    // lowest active slot holding this id, -1 if none
    function int slot_of_id(logic [ID_W-1:0] id);
      int slot;
      slot = -1;
      for (int i = NPEERS - 1; i >= 0; i--)
        if (occupied[i] && peer_ids[i] == id) slot = i;
      return slot;
    endfunction

    // lowest active slot whose learned port equals this one, -1 if none
    function int slot_of_port(logic [PORT_W-1:0] port);
      int slot;
      slot = -1;
      for (int i = NPEERS - 1; i >= 0; i--)
        if (occupied[i] && ports[i] == port) slot = i;
      return slot;
    endfunction

    // key of a random active slot; used to aim removes at live entries
    function bit live_key(output key_t k);
      int idx[$];
      k = '0;
      for (int i = 0; i < NPEERS; i++)
        if (occupied[i]) idx.push_back(i);
      if (idx.size() == 0) return 1'b0;
      k = keys[idx[$urandom_range(0, idx.size() - 1)]];
      return 1'b1;
    endfunction

    function res_t apply_operation(req_t beat);
      int                  slot;
      logic [STATUS_W-1:0] status;
      key_t                key;
      res_t                out;
      key    = {beat.pubkey_word3, beat.pubkey_word2, beat.pubkey_word1, beat.pubkey_word0};
      slot   = -1;
      status = ST_NOT_FOUND;
      case (beat.operation)
        OP_ADD: begin
          slot = slot_of_id(beat.peer_id);
          if (slot >= 0) begin
            status = ST_FOUND;                  // known id: entry left untouched
          end else begin
            for (int i = NPEERS - 1; i >= 0; i--)
              if (!occupied[i]) slot = i;
            if (slot >= 0) begin
              peer_ids[slot] = beat.peer_id;
              keys[slot]     = key;
              ports[slot]    = '0;
              occupied[slot] = 1'b1;
              live++;
              status = ST_ADDED;
            end else begin
              status = ST_FULL;
            end
          end
        end
        OP_REMOVE: begin
          for (int i = NPEERS - 1; i >= 0; i--)
            if (occupied[i] && keys[i] == key) slot = i;
          if (slot >= 0) begin
            occupied[slot] = 1'b0;
            live--;
            status = ST_REMOVED;
          end
        end
        OP_LOOKUP: begin
          slot = slot_of_port(beat.source_port);
          if (slot >= 0) begin
            status = ST_FOUND;
          end else begin
            slot = slot_of_port('0);
            if (slot >= 0) begin
              ports[slot] = beat.source_port;
              status = ST_LEARNED;
            end
          end
        end
        OP_FIND: begin
          slot = slot_of_id(beat.peer_id);
          if (slot >= 0) status = ST_FOUND;
        end
        default: begin
          status = ST_NOT_FOUND;
        end
      endcase
      out.status       = status;
      out.active_count = COUNT_W'(live);
      if (status == ST_NOT_FOUND || status == ST_FULL || slot < 0) begin
        out.slot_index      = '0;
        out.matched_peer_id = '0;
      end else begin
        out.slot_index      = SLOT_W'(slot);
        out.matched_peer_id = peer_ids[slot];
      end
      return out;
    endfunction

    function void note_request(req_t beat);
      pending_responses.push_back(apply_operation(beat));
    endfunction

    function void check_response(res_t got);
      res_t exp;
      if (pending_responses.size() == 0) begin
        $error("response beat with no request outstanding");
        mismatches++;
        return;
      end
      exp = pending_responses.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.slot_index !== exp.slot_index) begin
        $error("slot_index: expected %0d, got %0d", exp.slot_index, got.slot_index);
        mismatches++;
      end
      if (got.matched_peer_id !== exp.matched_peer_id) begin
        $error("matched_peer_id: expected 0x%04h, got 0x%04h",
               exp.matched_peer_id, got.matched_peer_id);
        mismatches++;
      end
      if (got.active_count !== exp.active_count) begin
        $error("active_count: expected %0d, got %0d", exp.active_count, got.active_count);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ptl_req_if req ();
  ptl_rsp_if rsp ();

  peer_table_with_port_learning_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  peer_table_mirror mirror = new();

  // Set by the sender to ask the receiver for its long hold-off; the
  // receiver raises hold_done once the stretch is over.
  bit rsp_hold  = 1'b0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  logic [ID_W-1:0]   id_pool[ID_POOL];
  key_t              key_pool[KEY_POOL];
  logic [PORT_W-1:0] port_pool[PORT_POOL];

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Idle length: mostly none or a few cycles, now and then a long stretch.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic key_t rand_key();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic req_t make_req(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                    key_t k, logic [PORT_W-1:0] port);
    req_t b;
    b.operation    = op;
    b.peer_id      = id;
    b.pubkey_word0 = k[63:0];
    b.pubkey_word1 = k[127:64];
    b.pubkey_word2 = k[191:128];
    b.pubkey_word3 = k[255:192];
    b.source_port  = port;
    return b;
  endfunction

  // Mostly well-formed traffic: ids, keys and ports come from small pools so
  // adds collide, removes hit and lookups find learned ports. Fill phases lean
  // on adds, drain phases on removes, so the table swings between the ends.
  function automatic req_t random_request(bit fill_phase);
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    key_t              k;
    key_t              hit;
    int                r;
    id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, ID_POOL-1)];
    k  = ($urandom_range(0, 4) < 2) ? rand_key() : key_pool[$urandom_range(0, KEY_POOL-1)];
    r  = $urandom_range(0, 99);
    if (r < 10)      port = '0;
    else if (r < 25) port = PORT_W'($urandom);
    else             port = port_pool[$urandom_range(0, PORT_POOL-1)];
    r = $urandom_range(0, 99);
    if (fill_phase)
      op = (r < 50) ? OP_ADD : (r < 60) ? OP_REMOVE : (r < 85) ? OP_LOOKUP : OP_FIND;
    else
      op = (r < 15) ? OP_ADD : (r < 55) ? OP_REMOVE : (r < 80) ? OP_LOOKUP : OP_FIND;
    if (op == OP_REMOVE && $urandom_range(0, 9) < 6 && mirror.live_key(hit)) k = hit;
    return make_req(op, id, k, port);
  endfunction

  // Present one beat from the falling edge and hold it until taken. valid is
  // left high so a following beat goes out back to back.
  task automatic send_beat(req_t b);
    @(negedge clk);
    req.valid        = 1'b1;
    req.operation    = b.operation;
    req.peer_id      = b.peer_id;
    req.pubkey_word0 = b.pubkey_word0;
    req.pubkey_word1 = b.pubkey_word1;
    req.pubkey_word2 = b.pubkey_word2;
    req.pubkey_word3 = b.pubkey_word3;
    req.source_port  = b.source_port;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. The response is checked
  // before the request is noted; a response leaves the block only after its
  // request has passed the input and response registers, so it cannot answer a
  // request taken on the same edge anyway.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        mirror.check_response(res_t'({rsp.status, rsp.slot_index,
                                      rsp.matched_peer_id, rsp.active_count}));
      if (req.valid && req.ready)
        mirror.note_request(req_t'({req.operation, req.peer_id, req.pubkey_word0,
                                    req.pubkey_word1, req.pubkey_word2,
                                    req.pubkey_word3, req.source_port}));
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("peer_table_with_port_learning_core regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, steady stretches with ready held high, and one
  // long hold-off on request from the sender so the block backs up into req.
  // --------------------------------------------------------------------------
  initial begin
    int  stall_left;
    int  cyc;
    bit  rx_steady;
    stall_left = 0;
    cyc        = 0;
    rx_steady  = 1'b0;
    rsp.ready  = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      if (rsp_hold && !hold_done) begin
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        rsp.ready = 1'b0;
        stall_left--;
      end else begin
        rsp.ready = 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) stall_left = gap_len();
      end
      if (cyc % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Sender: directed beats, then random traffic, then the final verdict.
  // --------------------------------------------------------------------------
  initial begin
    key_t zero_key;
    key_t ones_key;
    key_t k;
    bit   tx_steady;
    zero_key = '0;
    ones_key = '1;
    tx_steady = 1'b0;

    req.valid        = 1'b0;
    req.operation    = OP_ADD;
    req.peer_id      = '0;
    req.pubkey_word0 = '0;
    req.pubkey_word1 = '0;
    req.pubkey_word2 = '0;
    req.pubkey_word3 = '0;
    req.source_port  = '0;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Empty table: every kind of search misses.
    send_beat(make_req(OP_FIND,   16'hFFFF, zero_key, '0));
    send_beat(make_req(OP_LOOKUP, '0,       zero_key, 16'hFFFF));
    send_beat(make_req(OP_REMOVE, '0,       ones_key, '0));

    // Fill every slot back to back. Every fourth key is all zero, so remove
    // later meets duplicate keys; the id extremes sit at both ends.
    for (int i = 0; i < NPEERS; i++) begin
      if (i % 4 == 0)  k = zero_key;
      else if (i == 1) k = ones_key;
      else             k = rand_key();
      send_beat(make_req(OP_ADD, (i == 0) ? 16'h0000 : (i == NPEERS - 1) ? 16'hFFFF
                                 : ID_W'(16'h0100 + i), k, '0));
    end

    send_beat(make_req(OP_ADD,    16'h7777, rand_key(), '0));       // table full
    send_beat(make_req(OP_ADD,    16'h0103, ones_key,   '0));       // known id, kept as is
    send_beat(make_req(OP_LOOKUP, '0,       zero_key,   '0));       // zero port hits, no learn
    send_beat(make_req(OP_LOOKUP, '0,       zero_key,   16'hFFFF)); // learned by slot 0
    send_beat(make_req(OP_LOOKUP, '0,       zero_key,   16'hFFFF)); // now a hit
    send_beat(make_req(OP_FIND,   16'hFFFF, zero_key,   '0));
    send_beat(make_req(OP_REMOVE, '0,       zero_key,   '0));       // lowest of the duplicates
    send_beat(make_req(OP_REMOVE, '0,       zero_key,   '0));       // next duplicate
    send_beat(make_req(OP_LOOKUP, '0,       zero_key,   16'h8001)); // learns lowest unlearned

    foreach (id_pool[i])   id_pool[i]   = ID_W'($urandom);
    foreach (key_pool[i])  key_pool[i]  = rand_key();
    foreach (port_pool[i]) port_pool[i] = PORT_W'($urandom);
    id_pool[0]   = '0;
    id_pool[1]   = '1;
    key_pool[0]  = zero_key;
    key_pool[1]  = ones_key;
    port_pool[0] = '1;

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      // long receiver hold-off while beats keep coming with no gaps
      if (n == 200) rsp_hold = 1'b1;
      // let the block drain completely once mid-run
      if (n == 500) begin
        @(negedge clk);
        req.valid = 1'b0;
        while (mirror.pending_responses.size() != 0) @(negedge clk);
      end
      if (!tx_steady && !(rsp_hold && !hold_done)) idle_gap(gap_len());
      send_beat(random_request(((n / 100) % 2) == 0));
    end

    @(negedge clk);
    req.valid = 1'b0;

    while (mirror.pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.pending_responses.size() != 0) begin
      $error("%0d response beats never arrived", mirror.pending_responses.size());
      mirror.mismatches++;
    end
    if (mirror.mismatches == 0) begin
      $display("peer_table_with_port_learning_core regression: pass");
    end else begin
      $display("peer_table_with_port_learning_core regression: fail");
    end
    $finish;
  end

endmodule
